### hdl/pef_pkg.sv
// ----------------------------------------------------------------------------
// Pixel effect unit package
// Shared types and constants: effect mode codes, the internal operation
// classes, the queue entry that travels from front to back, the queue
// status and the dither thresholds.
// ----------------------------------------------------------------------------
package pef_pkg;

  // Effect mode register codes.
  localparam logic [2:0] MODE_RGB    = 3'd0;
  localparam logic [2:0] MODE_RED    = 3'd1;
  localparam logic [2:0] MODE_BLUE   = 3'd2;
  localparam logic [2:0] MODE_GREEN  = 3'd3;
  localparam logic [2:0] MODE_BRIGHT = 3'd4;
  localparam logic [2:0] MODE_GREY   = 3'd5;
  localparam logic [2:0] MODE_DITHER = 3'd6;

  // Operation class chosen by the front end for each pixel.
  typedef enum logic [2:0] {
    OP_RGB,
    OP_RED,
    OP_BLUE,
    OP_GREEN,
    OP_BRIGHT,
    OP_GREY,
    OP_DITHER
  } pef_op_t;

  // One classified pixel, with the first half of the arithmetic done.
  typedef struct packed {
    pef_op_t            op;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         y2;     // scaled and saturated luma
    logic signed [7:0]  u;      // chroma U, truncated toward zero
    logic signed [8:0]  v;      // chroma V, truncated toward zero
    logic [7:0]         luma;   // YCoCg-R luma
  } pef_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } pef_qstat_t;

  // Dither thresholds indexed by {sub_col, sub_row}.
  localparam logic [7:0] DITHER_THRESH [4] = '{8'd51, 8'd102, 8'd153, 8'd204};

endpackage

### hdl/pef_if.sv
// ----------------------------------------------------------------------------
// Pixel effect unit channels
// Valid/ready channels for source pixels, result pixels and the mode
// register write port.
// ----------------------------------------------------------------------------
interface pef_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

interface pef_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       sub_col;
  logic       sub_row;
  logic       last_of_pixel;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output sub_col, output sub_row, output last_of_pixel,
                  input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input sub_col, input sub_row, input last_of_pixel,
                  output ready);
endinterface

interface pef_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] effect_mode;

  modport source (output valid, output effect_mode, input ready);
  modport sink   (input valid, input effect_mode, output ready);
endinterface

### hdl/pixel_effect_unit_core.sv
// ----------------------------------------------------------------------------
// Pixel effect unit core
// Applies a configured color effect to a stream of RGB pixels.
// ----------------------------------------------------------------------------
// The unit accepts one RGB pixel per beat on the pix channel and returns
// result beats on the res channel. In the pass-through, single-channel,
// brightness and greyscale modes every pixel gives one beat and the unit
// sustains one pixel per clock cycle while the res channel is not stalled.
// In dither mode every pixel gives four beats, row by row, and the pixel rate
// there is set by the output register, which sends one beat per cycle while
// res is ready. A pixel passes the queue register and then the output
// register before its first result beat. The effect mode is written
// through the cfg channel, which is always ready, and must only change while
// no pixel is in flight. The front end computes the BT.601 luma and chroma
// terms and the YCoCg-R luma as the pixel is accepted; the back end forms
// the brightness result or the dither pattern from the queue head.
// ----------------------------------------------------------------------------
module pixel_effect_unit_core
  import pef_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  pef_cfg_if.sink       cfg,
  pef_pixel_if.sink     pix,
  pef_result_if.source  res
);

  // Front to queue: push strobe and the classified pixel.
  logic       push;
  pef_entry_t push_entry;

  // Queue to back: head entry and fill status; back to queue: pop strobe.
  pef_entry_t head;
  pef_qstat_t qstat;
  logic       pop;

  // The front end owns the mode register and stalls the pixel channel
  // whenever the queue is full.
  pef_front u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .pix   (pix),
    .qstat (qstat),
    .push  (push),
    .entry (push_entry)
  );

  // The queue lets the front keep accepting pixels while the back is busy
  // with the four beats of a dithered pixel or waits on a stalled output.
  pef_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // The back end pops a pixel as it loads that pixel's last beat.
  pef_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .res   (res)
  );

  // The queue is never pushed while full.
  assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("queue pushed while full");

  // The queue is never popped while empty.
  assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("queue popped while empty");

  // Once a non-final dither beat is taken, the next beat follows at once.
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && !res.last_of_pixel) |=> res.valid)
    else $error("dither beats of a pixel are not contiguous");

  // Only the fourth beat of a dithered pixel has both offsets set, and it is last.
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.sub_col && res.sub_row) |-> res.last_of_pixel)
    else $error("final dither beat not marked last");

endmodule

### hdl/pef_front.sv
// ----------------------------------------------------------------------------
// Pixel effect unit front end
// Holds the mode register, classifies each accepted pixel and computes its
// YUV terms and YCoCg-R luma before it is pushed into the queue.
// ----------------------------------------------------------------------------
module pef_front
  import pef_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pef_cfg_if.sink     cfg,
  pef_pixel_if.sink   pix,
  input  pef_qstat_t  qstat,
  output logic        push,
  output pef_entry_t  entry
);

  logic [2:0]         effect_mode;
  pef_op_t            op;
  logic [7:0]         r, g, b;
  logic [17:0]        y_sum;
  logic [9:0]         y3;
  logic [8:0]         y3_half;
  logic signed [19:0] r_s, g_s, b_s;
  logic signed [19:0] u_sum, v_sum, u_div, v_div;
  logic signed [8:0]  co, co_adj, co_half;
  logic signed [9:0]  t, cg, cg_adj, cg_half, l_full;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode <= MODE_RGB;
    end else if (cfg.valid && cfg.ready) begin
      effect_mode <= cfg.effect_mode;
    end
  end

  always_comb begin
    unique case (effect_mode)
      MODE_RED:    op = OP_RED;
      MODE_BLUE:   op = OP_BLUE;
      MODE_GREEN:  op = OP_GREEN;
      MODE_BRIGHT: op = OP_BRIGHT;
      MODE_GREY:   op = OP_GREY;
      MODE_DITHER: op = OP_DITHER;
      default:     op = OP_RGB;
    endcase
  end

  assign r = pix.in_red;
  assign g = pix.in_green;
  assign b = pix.in_blue;

  // Luma in Q10; the coefficients add up to 1024, so the sum fits 18 bits.
  assign y_sum   = 18'(r) * 18'd306 + 18'(g) * 18'd601 + 18'(b) * 18'd117;
  assign y3      = 10'(y_sum[17:10]) * 10'd3;
  assign y3_half = y3[9:1];

  assign r_s = $signed({12'b0, r});
  assign g_s = $signed({12'b0, g});
  assign b_s = $signed({12'b0, b});

  assign u_sum = -20'sd151 * r_s - 20'sd296 * g_s + 20'sd446 * b_s;
  assign v_sum =  20'sd630 * r_s - 20'sd527 * g_s - 20'sd102 * b_s;

  // Division by 1024 that truncates toward zero.
  assign u_div = (u_sum < 0) ? ((u_sum + 20'sd1023) >>> 10) : (u_sum >>> 10);
  assign v_div = (v_sum < 0) ? ((v_sum + 20'sd1023) >>> 10) : (v_sum >>> 10);

  // YCoCg-R luma with halving toward zero.
  assign co      = $signed({1'b0, r}) - $signed({1'b0, b});
  assign co_adj  = co + $signed({8'b0, co[8]});
  assign co_half = co_adj >>> 1;
  assign t       = $signed({2'b0, b}) + 10'(co_half);
  assign cg      = $signed({2'b0, g}) - t;
  assign cg_adj  = cg + $signed({9'b0, cg[9]});
  assign cg_half = cg_adj >>> 1;
  assign l_full  = t + cg_half;

  assign pix.ready = !qstat.full;
  assign push      = pix.valid && pix.ready;

  always_comb begin
    entry.op    = op;
    entry.red   = r;
    entry.green = g;
    entry.blue  = b;
    entry.y2    = (y3_half > 9'd255) ? 8'd255 : y3_half[7:0];
    entry.u     = u_div[7:0];
    entry.v     = v_div[8:0];
    entry.luma  = l_full[7:0];
  end

endmodule

### hdl/pef_queue.sv
// ----------------------------------------------------------------------------
// Pixel effect unit queue
// Small first-in first-out buffer of classified pixels between the front
// end and the back end.
// ----------------------------------------------------------------------------
module pef_queue
  import pef_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pef_entry_t  push_entry,
  input  logic        pop,
  output pef_entry_t  head,
  output pef_qstat_t  qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pef_entry_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);

endmodule

### hdl/pef_back.sv
// ----------------------------------------------------------------------------
// Pixel effect unit back end
// Finishes the arithmetic for the pixel at the head of the queue and drives
// the output register, one beat per pixel or four in dither mode.
// ----------------------------------------------------------------------------
module pef_back
  import pef_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  pef_entry_t    head,
  input  pef_qstat_t    qstat,
  output logic          pop,
  pef_result_if.source  res
);

  logic [1:0]         sub;
  logic               load;
  logic               take;
  logic               last_beat;
  logic signed [20:0] y2_q10, u_ext, v_ext;
  logic signed [20:0] r_sum, g_sum, b_sum;
  logic [7:0]         dith;
  logic [7:0]         red_next, green_next, blue_next;
  logic               col_next, row_next;

  logic       out_valid;
  logic [7:0] out_red, out_green, out_blue;
  logic       sub_col, sub_row, last_of_pixel;

  function automatic logic [7:0] clamp_q10(input logic signed [20:0] s);
    if (s < 0) begin
      clamp_q10 = 8'd0;
    end else if (s[20:10] > 11'sd255) begin
      clamp_q10 = 8'd255;
    end else begin
      clamp_q10 = s[17:10];
    end
  endfunction

  assign y2_q10 = $signed({3'b0, head.y2, 10'b0});
  assign u_ext  = 21'(head.u);
  assign v_ext  = 21'(head.v);
  assign r_sum  = y2_q10 + 21'sd1167 * v_ext;
  assign g_sum  = y2_q10 - 21'sd404 * u_ext - 21'sd595 * v_ext;
  assign b_sum  = y2_q10 + 21'sd2081 * u_ext;

  // Dither beats go row by row: sub[1] is the row and sub[0] the column.
  assign dith = (head.luma > DITHER_THRESH[{sub[0], sub[1]}]) ? 8'd255 : 8'd0;

  always_comb begin
    red_next   = head.red;
    green_next = head.green;
    blue_next  = head.blue;
    col_next   = 1'b0;
    row_next   = 1'b0;
    last_beat  = 1'b1;
    case (head.op)
      OP_RED: begin
        green_next = 8'd0;
        blue_next  = 8'd0;
      end
      OP_BLUE: begin
        red_next   = 8'd0;
        green_next = 8'd0;
      end
      OP_GREEN: begin
        red_next  = 8'd0;
        blue_next = 8'd0;
      end
      OP_BRIGHT: begin
        red_next   = clamp_q10(r_sum);
        green_next = clamp_q10(g_sum);
        blue_next  = clamp_q10(b_sum);
      end
      OP_GREY: begin
        red_next   = head.luma;
        green_next = head.luma;
        blue_next  = head.luma;
      end
      OP_DITHER: begin
        red_next   = dith;
        green_next = dith;
        blue_next  = dith;
        col_next   = sub[0];
        row_next   = sub[1];
        last_beat  = (sub == 2'd3);
      end
      default: begin
      end
    endcase
  end

  assign load = !out_valid || res.ready;
  assign take = load && !qstat.empty;
  assign pop  = take && last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= '0;
    end else if (load) begin
      out_valid <= !qstat.empty;
      if (take) begin
        sub <= last_beat ? 2'd0 : sub + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_red       <= red_next;
      out_green     <= green_next;
      out_blue      <= blue_next;
      sub_col       <= col_next;
      sub_row       <= row_next;
      last_of_pixel <= last_beat;
    end
  end

  assign res.valid         = out_valid;
  assign res.out_red       = out_red;
  assign res.out_green     = out_green;
  assign res.out_blue      = out_blue;
  assign res.sub_col       = sub_col;
  assign res.sub_row       = sub_row;
  assign res.last_of_pixel = last_of_pixel;

endmodule

### tb/sv/tb_pixel_effect_unit_core.sv
// ----------------------------------------------------------------------------
// Pixel effect unit core testbench
// Sends RGB pixels through every effect mode and checks each result beat,
// field by field, against an in-order prediction of the colour arithmetic.
// Both channels idle and stall at random. The result side also holds off
// once for a long stretch so that the unit fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_pixel_effect_unit_core;
  import pef_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The mode field is three bits wide, so the one code that has no effect of
  // its own can still be written. The unit treats it as pass-through.
  localparam logic [2:0] MODE_SPARE = 3'd7;

  // Consecutive cycles without any accepted beat before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Cycles the result side holds ready low during the back-pressure test.
  localparam int HOLD_CYCLES = 60;
  // Idle chance per cycle, in percent, on either channel.
  localparam int IDLE_PCT = 17;

  // One result beat as it appears on the result channel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       col;
    logic       row;
    logic       last_beat;
  } px_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the effect mode, turns every accepted
  // pixel into the result beats it must cause, and matches result beats
  // against them in order.
  // --------------------------------------------------------------------------
  class effect_scoreboard;
    logic [2:0] mode;
    px_result_t awaited_beats[$];
    int         errors;

    function new();
      mode   = MODE_RGB;
      errors = 0;
    endfunction

    function void set_mode(logic [2:0] m);
      mode = m;
    endfunction

    function int pending();
      return awaited_beats.size();
    endfunction

    function void push_beat(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic col, logic row, logic last_beat);
      px_result_t beat;
      beat.red       = r;
      beat.green     = g;
      beat.blue      = b;
      beat.col       = col;
      beat.row       = row;
      beat.last_beat = last_beat;
      awaited_beats.push_back(beat);
    endfunction

    // A negative Q10 sum gives 0; anything past 255 after scaling gives 255.
    function logic [7:0] sat_q10(int sum);
      int whole;
      if (sum < 0) return 8'd0;
      whole = sum >>> 10;
      return (whole > 255) ? 8'd255 : whole[7:0];
    endfunction

    // YCoCg-R luma; SystemVerilog integer division truncates toward zero.
    function logic [7:0] grey_level(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int co;
      int t;
      int cg;
      int lum;
      co  = int'(r) - int'(b);
      t   = int'(b) + co / 2;
      cg  = int'(g) - t;
      lum = t + cg / 2;
      return lum[7:0];
    endfunction

    // BT.601 brightness boost with the luma scaled by one and a half.
    function void push_bright(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int rr;
      int gg;
      int bb;
      int y;
      int u;
      int v;
      int y2;
      rr = r;
      gg = g;
      bb = b;
      y  = (306 * rr + 601 * gg + 117 * bb) >>> 10;
      u  = (-151 * rr - 296 * gg + 446 * bb) / 1024;
      v  = (630 * rr - 527 * gg - 102 * bb) / 1024;
      y2 = (3 * y) >>> 1;
      if (y2 > 255) y2 = 255;
      push_beat(sat_q10(y2 * 1024 + 1167 * v),
                sat_q10(y2 * 1024 - 404 * u - 595 * v),
                sat_q10(y2 * 1024 + 2081 * u), 1'b0, 1'b0, 1'b1);
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [7:0] lum;
      logic [1:0] pos;
      logic [7:0] shade;
      case (mode)
        MODE_RED:    push_beat(r, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
        MODE_BLUE:   push_beat(8'd0, 8'd0, b, 1'b0, 1'b0, 1'b1);
        MODE_GREEN:  push_beat(8'd0, g, 8'd0, 1'b0, 1'b0, 1'b1);
        MODE_BRIGHT: push_bright(r, g, b);
        MODE_GREY: begin
          lum = grey_level(r, g, b);
          push_beat(lum, lum, lum, 1'b0, 1'b0, 1'b1);
        end
        MODE_DITHER: begin
          lum = grey_level(r, g, b);
          // Row-major order: pos[1] is the row, pos[0] the column.
          for (int k = 0; k < 4; k++) begin
            pos   = k[1:0];
            shade = (lum > DITHER_THRESH[{pos[0], pos[1]}]) ? 8'd255 : 8'd0;
            push_beat(shade, shade, shade, pos[0], pos[1], k == 3);
          end
        end
        default:     push_beat(r, g, b, 1'b0, 1'b0, 1'b1);
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task check_result(px_result_t got);
      px_result_t want;
      if (awaited_beats.size() == 0) begin
        report_mismatch($sformatf("beat with nothing outstanding: %0d/%0d/%0d",
                                  got.red, got.green, got.blue));
        return;
      end
      want = awaited_beats.pop_front();
      compare_field("out_red", got.red, want.red);
      compare_field("out_green", got.green, want.green);
      compare_field("out_blue", got.blue, want.blue);
      compare_field("sub_col", got.col, want.col);
      compare_field("sub_row", got.row, want.row);
      compare_field("last_of_pixel", got.last_beat, want.last_beat);
    endtask
  endclass

  logic clk;
  logic rst;

  pef_cfg_if    cfg_ch();
  pef_pixel_if  pix_ch();
  pef_result_if res_ch();

  pixel_effect_unit_core dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .pix (pix_ch),
    .res (res_ch)
  );

  effect_scoreboard sb = new();

  // Idling switches for the two sides, and the request for one long hold-off
  // on the result side.
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_req     = 1'b0;

  // Modes of the random phases. Both ends of the mode range are in the list,
  // and dither comes twice because it is the only mode with several beats.
  logic [2:0] phase_modes [10] = '{MODE_DITHER, MODE_RGB, MODE_BRIGHT, MODE_GREY,
                                   MODE_RED, MODE_BLUE, MODE_GREEN, MODE_SPARE,
                                   MODE_DITHER, MODE_BRIGHT};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Every input starts at a known value while reset is held.
  initial begin
    rst                <= 1'b1;
    pix_ch.valid       <= 1'b0;
    pix_ch.in_red      <= 8'd0;
    pix_ch.in_green    <= 8'd0;
    pix_ch.in_blue     <= 8'd0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.effect_mode <= MODE_RGB;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Result side. Every beat taken at a rising edge is checked there; ready
  // for the next cycle is then chosen. A hold-off request drops ready for a
  // fixed stretch, counted here, while the sender keeps offering pixels.
  initial begin
    px_result_t got;
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        got.red       = res_ch.out_red;
        got.green     = res_ch.out_green;
        got.blue      = res_ch.out_blue;
        got.col       = res_ch.sub_col;
        got.row       = res_ch.sub_row;
        got.last_beat = res_ch.last_of_pixel;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else if (sink_idle_en) begin
        res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog. Any accepted beat on any channel restarts the count; a run that
  // goes too long with no progress at all is declared hung.
  always @(posedge clk) begin
    int stall_cycles;
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one pixel, after a random gap when idling is on, and returns
  // right after the rising edge at which the beat was taken. Each cycle of
  // the gap is drawn on its own, so valid is low in about one cycle in six.
  // Valid stays high so that a following call can present the next pixel
  // without a bubble.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.in_red   <= r;
    pix_ch.in_green <= g;
    pix_ch.in_blue  <= b;
    do @(posedge clk); while (!pix_ch.ready);
    sb.note_pixel(r, g, b);
  endtask

  // Stops offering pixels and waits until every predicted beat has come
  // back. An edge always passes with valid low, so the next raise of valid
  // never shares a time step with this drop.
  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mode changes happen only with nothing in flight. Every pixel causes at
  // least one beat, so an empty scoreboard means the unit is idle.
  task automatic write_mode(input logic [2:0] m);
    drain_results();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.effect_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_mode(m);
  endtask

  // Channel values lean toward the extremes a quarter of the time.
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int n_items;
    @(negedge rst);
    @(posedge clk);

    // Directed part. The first two pixels run at the reset mode, which must
    // behave as pass-through without any register write.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    write_mode(MODE_RED);
    send_pixel(8'd255, 8'd128, 8'd1);
    write_mode(MODE_BLUE);
    send_pixel(8'd1, 8'd128, 8'd255);
    write_mode(MODE_GREEN);
    send_pixel(8'd7, 8'd255, 8'd200);

    // Brightness: white saturates the scaled luma, pure primaries push the
    // chroma terms far enough to hit the upper clamp.
    write_mode(MODE_BRIGHT);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);

    // Greyscale: negative odd differences check that halving truncates
    // toward zero rather than rounding down.
    write_mode(MODE_GREY);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd4);
    send_pixel(8'd255, 8'd255, 8'd255);

    // Dither: a neutral grey gives its own level as luma, so these land on
    // and just past the thresholds, which are strict.
    write_mode(MODE_DITHER);
    send_pixel(8'd51, 8'd51, 8'd51);
    send_pixel(8'd52, 8'd52, 8'd52);
    send_pixel(8'd102, 8'd102, 8'd102);
    send_pixel(8'd153, 8'd153, 8'd153);
    send_pixel(8'd204, 8'd204, 8'd204);
    send_pixel(8'd205, 8'd205, 8'd205);

    write_mode(MODE_SPARE);
    send_pixel(8'd18, 8'd52, 8'd200);

    // Random phases, one mode each. Phase 2 runs with no idling on either
    // side. In phase 1 the result side holds off for a long stretch while
    // pixels keep coming, which fills the unit and stalls its input. In
    // phase 4 the sender pauses until every outstanding beat has arrived.
    for (int ph = 0; ph < 10; ph++) begin
      write_mode(phase_modes[ph]);
      src_idle_en  = (ph != 2);
      sink_idle_en = (ph != 2);
      n_items      = (ph == 2) ? 30 : 8;
      for (int i = 0; i < n_items; i++) begin
        if (ph == 1 && i == 1) hold_req = 1'b1;
        if (ph == 4 && i == 5) drain_results();
        send_pixel(rand_chan(), rand_chan(), rand_chan());
      end
    end

    // Wind down: every beat must arrive, and nothing more may follow in the
    // next few cycles. The watchdog bounds the wait.
    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
